>>> hw/rtl/ppce_pkg.sv
// Shared constants and types for the pulse peak and charge extractor.
package ppce_pkg;

  // The pedestal region covers sample indices 1 to 100.
  localparam int unsigned PED_FIRST = 1;
  localparam int unsigned PED_LAST  = 100;
  localparam int unsigned SCALE     = 100;

  // Fixed widths of the window registers and of the result fields.
  localparam int WSTART_W   = 10;
  localparam int WEND_W     = 11;
  localparam int PEAK_W     = 20;
  localparam int INTEGRAL_W = 30;
  localparam int STATUS_W   = 2;
  localparam int REG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Reset values of the window registers.
  localparam logic [WSTART_W-1:0] WSTART_RESET = 10'd0;
  localparam logic [WEND_W-1:0]   WEND_RESET   = 11'd1024;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_WINDOW_START = 1'b0,
    REG_WINDOW_END   = 1'b1
  } reg_idx_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_SHORT = 2'd2
  } status_t;

  // Integration window as configured.
  typedef struct packed {
    logic [WSTART_W-1:0] start;
    logic [WEND_W-1:0]   stop;
  } win_t;

endpackage

>>> hw/rtl/ppce_ifs.sv
// Channel interfaces: sample stream, result stream and configuration writes.
interface ppce_sample_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface ppce_result_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] peak_x100;
  logic signed [29:0] integral_x100;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output peak_x100, output integral_x100, output status,
                  output last, input ready);
  modport sink   (input valid, input peak_x100, input integral_x100, input status,
                  input last, output ready);
endinterface

interface ppce_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [10:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/ppce_accum.sv
// Running pedestal, window sum and window minimum, with the end-of-waveform register.
module ppce_accum #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 12,
  parameter int IDX_W       = $clog2(MAX_SAMPLES + 1),
  parameter int PED_W       = SAMPLE_BITS + 7,
  parameter int WS_W        = SAMPLE_BITS + IDX_W
) (
  input  logic                      clk,
  input  logic                      rst,
  // Registered sample beat.
  input  logic                      s_valid,
  input  logic [SAMPLE_BITS-1:0]    s_sample,
  input  logic                      s_last,
  output logic                      s_go,
  input  ppce_pkg::win_t            win,
  // End-of-waveform totals.
  input  logic                      out_free,
  output logic                      fin_valid,
  output logic [PED_W-1:0]          fin_ped,
  output logic [WS_W-1:0]           fin_wsum,
  output logic [SAMPLE_BITS-1:0]    fin_wmin,
  output logic [ppce_pkg::WEND_W-1:0] fin_len,
  output ppce_pkg::status_t         fin_status
);
  import ppce_pkg::*;

  localparam int CMP_W = (IDX_W > WEND_W) ? IDX_W : WEND_W;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES);

  logic [IDX_W-1:0]       sample_index;
  logic [PED_W-1:0]       pedestal_sum;
  logic [WS_W-1:0]        window_sum;
  logic [SAMPLE_BITS-1:0] window_minimum;

  logic [IDX_W-1:0]       sample_index_next;
  logic [PED_W-1:0]       pedestal_sum_next;
  logic [WS_W-1:0]        window_sum_next;
  logic [SAMPLE_BITS-1:0] window_minimum_next;
  logic [CMP_W-1:0]       idx_c;
  logic                   in_range;
  logic                   in_ped;
  logic                   in_win;
  status_t                status_c;

  // A last sample may only move on when the totals register is free.
  assign s_go = s_valid && (!s_last || !fin_valid || out_free);

  // Where the current sample falls.
  always_comb begin
    idx_c    = CMP_W'(sample_index);
    in_range = sample_index < IDX_MAX;
    in_ped   = in_range && (idx_c >= CMP_W'(PED_FIRST)) && (idx_c <= CMP_W'(PED_LAST));
    in_win   = in_range && (idx_c >= CMP_W'(win.start)) && (idx_c < CMP_W'(win.stop));
  end

  // Updated accumulators including the current sample.
  always_comb begin
    pedestal_sum_next   = pedestal_sum;
    window_sum_next     = window_sum;
    window_minimum_next = window_minimum;
    sample_index_next   = in_range ? sample_index + 1'b1 : IDX_MAX;
    if (in_ped) begin
      pedestal_sum_next = pedestal_sum + PED_W'(s_sample);
    end
    if (in_win) begin
      window_sum_next = window_sum + WS_W'(s_sample);
      if (s_sample < window_minimum) begin
        window_minimum_next = s_sample;
      end
    end
  end

  // Waveform status, checked in order of precedence.
  always_comb begin
    priority if (CMP_W'(sample_index_next) < CMP_W'(PED_LAST + 1)) begin
      status_c = STATUS_SHORT;
    end else if (win.start >= WSTART_W'(win.stop) && win.stop[WEND_W-1] == 1'b0) begin
      status_c = STATUS_EMPTY;
    end else if (CMP_W'(win.stop) > CMP_W'(sample_index_next)) begin
      status_c = STATUS_SHORT;
    end else begin
      status_c = STATUS_OK;
    end
  end

  // Accumulator state, cleared after each waveform.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index   <= '0;
      pedestal_sum   <= '0;
      window_sum     <= '0;
      window_minimum <= '1;
    end else if (s_go) begin
      if (s_last) begin
        sample_index   <= '0;
        pedestal_sum   <= '0;
        window_sum     <= '0;
        window_minimum <= '1;
      end else begin
        sample_index   <= sample_index_next;
        pedestal_sum   <= pedestal_sum_next;
        window_sum     <= window_sum_next;
        window_minimum <= window_minimum_next;
      end
    end
  end

  // Totals register handed to the output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (s_go && s_last) begin
      fin_valid <= 1'b1;
    end else if (out_free) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_go && s_last) begin
      fin_ped    <= pedestal_sum_next;
      fin_wsum   <= window_sum_next;
      fin_wmin   <= window_minimum_next;
      fin_len    <= win.stop - WEND_W'(win.start);
      fin_status <= status_c;
    end
  end

endmodule

>>> hw/rtl/pulse_peak_and_charge_extractor.sv
// Top level: input register, window registers, accumulators and result register.
// Accepts one sample per cycle unless the result path holds back a last sample; the result
// of a waveform passes through the input register, totals register and result register.
// The one non-constant multiplier (window length times pedestal sum) sits before the result register.
// Synchronous active-high reset clears all beats in flight and the accumulators, and sets
// the window to start 0, end 1024.
module pulse_peak_and_charge_extractor #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 12
) (
  input  logic           clk,
  input  logic           rst,
  ppce_sample_if.sink    samples,
  ppce_result_if.source  results,
  ppce_cfg_if.sink       cfg
);
  import ppce_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SAMPLES + 1);
  localparam int PED_W  = SAMPLE_BITS + 7;
  localparam int WS_W   = SAMPLE_BITS + IDX_W;
  localparam int PROD_W = WEND_W + PED_W;
  localparam int SWS_W  = WS_W + 7;
  localparam int INT_A  = ((PROD_W > SWS_W) ? PROD_W : SWS_W) + 1;
  localparam int INT_W  = (INT_A > INTEGRAL_W) ? INT_A : INTEGRAL_W;
  localparam int PK_A   = ((PED_W > SAMPLE_BITS + 7) ? PED_W : SAMPLE_BITS + 7) + 1;
  localparam int PK_W   = (PK_A > PEAK_W) ? PK_A : PEAK_W;

  win_t                   win;
  logic                   s_valid;
  logic [SAMPLE_BITS-1:0] s_sample;
  logic                   s_last;
  logic                   s_go;
  logic                   out_free;
  logic                   fin_valid;
  logic [PED_W-1:0]       fin_ped;
  logic [WS_W-1:0]        fin_wsum;
  logic [SAMPLE_BITS-1:0] fin_wmin;
  logic [WEND_W-1:0]      fin_len;
  status_t                fin_status;
  logic [INT_W-1:0]       integral_c;
  logic [PK_W-1:0]        peak_c;

  // Configuration writes are taken in any cycle.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.start <= WSTART_RESET;
      win.stop  <= WEND_RESET;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_WINDOW_START: win.start <= cfg.data[WSTART_W-1:0];
        REG_WINDOW_END:   win.stop  <= cfg.data;
        default:          win       <= win;
      endcase
    end
  end

  // Input register; it refills in the same cycle it drains.
  assign samples.ready = !s_valid || s_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      s_valid <= 1'b1;
    end else if (s_go) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s_sample <= samples.sample;
      s_last   <= samples.last_sample;
    end
  end

  ppce_accum #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_W       (IDX_W),
    .PED_W       (PED_W),
    .WS_W        (WS_W)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_valid),
    .s_sample   (s_sample),
    .s_last     (s_last),
    .s_go       (s_go),
    .win        (win),
    .out_free   (out_free),
    .fin_valid  (fin_valid),
    .fin_ped    (fin_ped),
    .fin_wsum   (fin_wsum),
    .fin_wmin   (fin_wmin),
    .fin_len    (fin_len),
    .fin_status (fin_status)
  );

  // Peak and integral, both times 100, wrapping to their field widths.
  always_comb begin
    integral_c = INT_W'(fin_len) * INT_W'(fin_ped) - INT_W'(fin_wsum) * INT_W'(SCALE);
    peak_c     = PK_W'(fin_ped) - PK_W'(fin_wmin) * PK_W'(SCALE);
  end

  // Result register.
  assign out_free = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (fin_valid && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && out_free) begin
      results.status <= fin_status;
      results.last   <= 1'b1;
      if (fin_status == STATUS_OK) begin
        results.peak_x100     <= peak_c[PEAK_W-1:0];
        results.integral_x100 <= integral_c[INTEGRAL_W-1:0];
      end else begin
        results.peak_x100     <= '0;
        results.integral_x100 <= '0;
      end
    end
  end

endmodule

>>> hw/rtl/ppce_checker.sv
// Port-level checks for the pulse peak and charge extractor, bound to the top level.
module ppce_checker (
  input logic               clk,
  input logic               rst,
  input logic               valid,
  input logic               ready,
  input logic signed [19:0] peak_x100,
  input logic signed [29:0] integral_x100,
  input logic [1:0]         status,
  input logic               last
);
  import ppce_pkg::*;

  // No result beat is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !valid)
    else $error("result valid right after reset");

  // An error status carries zero peak and integral.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && status != STATUS_OK) |-> (peak_x100 == '0 && integral_x100 == '0))
    else $error("nonzero result fields with error status");

  // Every result beat closes a waveform and carries a defined status.
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last && (status == STATUS_OK || status == STATUS_EMPTY ||
                        status == STATUS_SHORT)))
    else $error("bad last flag or status code");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=> (valid && $stable(peak_x100) && $stable(integral_x100) &&
                           $stable(status)))
    else $error("stalled result beat changed");

endmodule

bind pulse_peak_and_charge_extractor ppce_checker u_ppce_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (results.valid),
  .ready         (results.ready),
  .peak_x100     (results.peak_x100),
  .integral_x100 (results.integral_x100),
  .status        (results.status),
  .last          (results.last)
);
